/* rtl/core/linear_adsr_envelope_macros.svh */
// ----------------------------------------------------------------------------
// Linear ADSR envelope assertion macros
// Shared concurrent assertion wrappers, clocked on clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ADSR_ENVELOPE_MACROS_SVH
`define LINEAR_ADSR_ENVELOPE_MACROS_SVH

// same-cycle implication
`define LAE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("envelope check failed");

// next-cycle implication
`define LAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("envelope check failed");

`endif

/* rtl/core/lae_pkg.sv */
// ----------------------------------------------------------------------------
// lae_pkg
// Stage codes, register map, sequencer steps and control store.
// ----------------------------------------------------------------------------
`default_nettype none

package lae_pkg;

    typedef enum logic [2:0] {
        STAGE_ATTACK  = 3'd0,
        STAGE_DECAY   = 3'd1,
        STAGE_SUSTAIN = 3'd2,
        STAGE_RELEASE = 3'd3,
        STAGE_OFF     = 3'd4
    } stage_t;

    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_SUSTAIN = 2'd2,
        REG_RELEASE = 2'd3
    } reg_idx_t;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [2:0] {
        STEP_WAIT  = 3'd0,
        STEP_CLASS = 3'd1,
        STEP_MUL   = 3'd2,
        STEP_DIV   = 3'd3,
        STEP_EMIT  = 3'd4
    } step_t;

    typedef enum logic [2:0] {
        COND_ALWAYS   = 3'd0,
        COND_IN_VALID = 3'd1,
        COND_NEED_DIV = 3'd2,
        COND_DIV_LAST = 3'd3,
        COND_OUT_FREE = 3'd4
    } cond_t;

    typedef struct packed {
        logic  in_ready;
        logic  ld_class;
        logic  ld_mul;
        logic  do_div;
        logic  emit;
        cond_t cond;
        step_t jump_true;
        step_t jump_false;
    } ctrl_t;

    // control store: one word per step
    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        w = '{in_ready: 1'b0, ld_class: 1'b0, ld_mul: 1'b0, do_div: 1'b0, emit: 1'b0,
              cond: COND_ALWAYS, jump_true: STEP_WAIT, jump_false: STEP_WAIT};
        unique case (step)
            STEP_WAIT:
            begin
                w.in_ready   = 1'b1;
                w.cond       = COND_IN_VALID;
                w.jump_true  = STEP_CLASS;
                w.jump_false = STEP_WAIT;
            end
            STEP_CLASS:
            begin
                w.ld_class   = 1'b1;
                w.cond       = COND_NEED_DIV;
                w.jump_true  = STEP_MUL;
                w.jump_false = STEP_EMIT;
            end
            STEP_MUL:
            begin
                w.ld_mul     = 1'b1;
                w.cond       = COND_ALWAYS;
                w.jump_true  = STEP_DIV;
                w.jump_false = STEP_DIV;
            end
            STEP_DIV:
            begin
                w.do_div     = 1'b1;
                w.cond       = COND_DIV_LAST;
                w.jump_true  = STEP_EMIT;
                w.jump_false = STEP_DIV;
            end
            STEP_EMIT:
            begin
                w.emit       = 1'b1;
                w.cond       = COND_OUT_FREE;
                w.jump_true  = STEP_WAIT;
                w.jump_false = STEP_EMIT;
            end
            default:
            begin
                w.cond       = COND_ALWAYS;
                w.jump_true  = STEP_WAIT;
                w.jump_false = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lae_if.sv */
// ----------------------------------------------------------------------------
// lae_if
// Valid/ready channels: sample tick in, envelope word out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lae_in_if;
    logic valid;
    logic ready;
    logic gate;

    modport source (output valid, output gate, input ready);
    modport sink   (input valid, input gate, output ready);
endinterface

interface lae_out_if #(
    parameter int LEVEL_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] amplitude;
    logic [2:0]            stage;

    modport source (output valid, output amplitude, output stage, input ready);
    modport sink   (input valid, input amplitude, input stage, output ready);
endinterface

`default_nettype wire

/* rtl/core/linear_adsr_envelope.sv */
// ----------------------------------------------------------------------------
// linear_adsr_envelope
// Linear attack/decay/sustain/release envelope, one amplitude word per tick.
// ----------------------------------------------------------------------------
// Each input word (gate) yields one output word (amplitude in unsigned
// Q1.(LEVEL_BITS-1), full scale 2**(LEVEL_BITS-1), plus stage code). A tick
// in attack, decay or release runs through wait, classify, multiply, a
// one-bit-per-cycle restoring divider and emit. Sustain and off ticks skip
// the multiply and the divider. One word is in work at a time; the output
// register lets the next word be accepted while a result waits to be
// taken. Registers sit on an APB port at byte addresses 0, 4, 8, 12:
// attack, decay, sustain, release; write them only while the block is
// idle.
`default_nettype none

`include "linear_adsr_envelope_macros.svh"

module linear_adsr_envelope
    import lae_pkg::*;
#(
    parameter int COUNT_BITS = 18,
    parameter int LEVEL_BITS = 16
)(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    lae_in_if.sink                        din,
    lae_out_if.source                     dout,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    localparam int CNT_BITS = $clog2(LEVEL_BITS + 1);
    localparam logic [LEVEL_BITS-1:0] FULL_SCALE = {1'b1, {(LEVEL_BITS-1){1'b0}}};

    // ---------------- configuration ----------------
    logic [COUNT_BITS-1:0] attack_reg;
    logic [COUNT_BITS-1:0] decay_reg;
    logic [LEVEL_BITS-1:0] sustain_reg;
    logic [COUNT_BITS-1:0] release_reg;
    logic                  cfg_wr;
    reg_idx_t              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= COUNT_BITS'(48000);
            decay_reg   <= COUNT_BITS'(72000);
            sustain_reg <= LEVEL_BITS'(16384);
            release_reg <= COUNT_BITS'(96000);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ATTACK:  attack_reg  <= pwdata[COUNT_BITS-1:0];
                REG_DECAY:   decay_reg   <= pwdata[COUNT_BITS-1:0];
                REG_SUSTAIN: sustain_reg <= pwdata[LEVEL_BITS-1:0];
                REG_RELEASE: release_reg <= pwdata[COUNT_BITS-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ATTACK:  prdata = APB_DATA_BITS'(attack_reg);
            REG_DECAY:   prdata = APB_DATA_BITS'(decay_reg);
            REG_SUSTAIN: prdata = APB_DATA_BITS'(sustain_reg);
            REG_RELEASE: prdata = APB_DATA_BITS'(release_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    step_t step_reg, step_next;
    ctrl_t ctrl;
    logic  cond_true;
    logic  need_div;
    logic  out_free;
    logic  [CNT_BITS-1:0] cnt_reg;

    logic  out_valid_reg;

    assign ctrl     = ucode_rom(step_reg);
    assign out_free = !out_valid_reg || dout.ready;

    always_comb
    begin
        unique case (ctrl.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_IN_VALID: cond_true = din.valid;
            COND_NEED_DIV: cond_true = need_div;
            COND_DIV_LAST: cond_true = (cnt_reg == CNT_BITS'(1));
            COND_OUT_FREE: cond_true = out_free;
            default:       cond_true = 1'b1;
        endcase
        step_next = cond_true ? ctrl.jump_true : ctrl.jump_false;
    end

    always_comb
    begin
        din.ready = ctrl.in_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_WAIT;
        else
            step_reg <= step_next;
    end

    // ---------------- envelope state ----------------
    logic [COUNT_BITS:0]   pos_reg;
    logic [COUNT_BITS-1:0] rel_reg;
    stage_t                cur_stage_reg;
    logic                  gate_reg;

    logic [LEVEL_BITS-1:0] s_clamp;
    logic [COUNT_BITS:0]   a_plus_d;
    logic [COUNT_BITS:0]   p_minus_a;
    stage_t                stage_cls;
    logic [LEVEL_BITS-1:0] m_cls;
    logic [COUNT_BITS-1:0] x_cls;
    logic [COUNT_BITS-1:0] d_cls;
    logic [COUNT_BITS:0]   pos_cls;
    logic [COUNT_BITS-1:0] rel_cls;

    assign s_clamp   = (sustain_reg > FULL_SCALE) ? FULL_SCALE : sustain_reg;
    assign a_plus_d  = {1'b0, attack_reg} + {1'b0, decay_reg};
    assign p_minus_a = pos_reg - {1'b0, attack_reg};

    always_comb
    begin
        stage_cls = STAGE_OFF;
        m_cls     = s_clamp;
        x_cls     = rel_reg;
        d_cls     = release_reg;
        pos_cls   = '0;
        rel_cls   = '0;
        if (gate_reg)
        begin
            // position saturates at all ones
            pos_cls = (pos_reg == '1) ? pos_reg : pos_reg + (COUNT_BITS+1)'(1);
            if (pos_reg < {1'b0, attack_reg})
            begin
                stage_cls = STAGE_ATTACK;
                m_cls     = FULL_SCALE;
                x_cls     = pos_reg[COUNT_BITS-1:0];
                d_cls     = attack_reg;
            end
            else if (pos_reg < a_plus_d)
            begin
                stage_cls = STAGE_DECAY;
                m_cls     = FULL_SCALE - s_clamp;
                x_cls     = p_minus_a[COUNT_BITS-1:0];
                d_cls     = decay_reg;
            end
            else
                stage_cls = STAGE_SUSTAIN;
        end
        else if ((cur_stage_reg == STAGE_SUSTAIN || cur_stage_reg == STAGE_RELEASE)
                 && (rel_reg < release_reg))
        begin
            stage_cls = STAGE_RELEASE;
            pos_cls   = pos_reg;
            rel_cls   = rel_reg + COUNT_BITS'(1);
        end
    end

    assign need_div = (stage_cls == STAGE_ATTACK) || (stage_cls == STAGE_DECAY)
                   || (stage_cls == STAGE_RELEASE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            rel_reg       <= '0;
            cur_stage_reg <= STAGE_OFF;
        end
        else if (ctrl.ld_class)
        begin
            pos_reg       <= pos_cls;
            rel_reg       <= rel_cls;
            cur_stage_reg <= stage_cls;
        end
    end

    // ---------------- datapath: multiply, then restoring divide ----------------
    logic [LEVEL_BITS-1:0]            m_reg;
    logic [COUNT_BITS-1:0]            x_reg;
    logic [COUNT_BITS-1:0]            div_reg;
    logic [LEVEL_BITS-1:0]            s_reg;
    logic [COUNT_BITS-1:0]            rem_reg;
    logic [LEVEL_BITS-1:0]            lo_reg;   // numerator low bits, then quotient
    logic [LEVEL_BITS+COUNT_BITS-1:0] product;
    logic [COUNT_BITS:0]              trial;
    logic [COUNT_BITS:0]              trial_diff;
    logic                             q_bit;

    assign product    = (LEVEL_BITS+COUNT_BITS)'(m_reg) * (LEVEL_BITS+COUNT_BITS)'(x_reg);
    assign trial      = {rem_reg, lo_reg[LEVEL_BITS-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign q_bit      = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
            gate_reg <= din.gate;
        if (ctrl.ld_class)
        begin
            m_reg   <= m_cls;
            x_reg   <= x_cls;
            div_reg <= d_cls;
            s_reg   <= s_clamp;
        end
        if (ctrl.ld_mul)
        begin
            // high part is below the divisor since x < divisor
            rem_reg <= product[LEVEL_BITS+COUNT_BITS-1:LEVEL_BITS];
            lo_reg  <= product[LEVEL_BITS-1:0];
        end
        else if (ctrl.do_div)
        begin
            rem_reg <= q_bit ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            lo_reg  <= {lo_reg[LEVEL_BITS-2:0], q_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (ctrl.ld_mul)
            cnt_reg <= CNT_BITS'(LEVEL_BITS);
        else if (ctrl.do_div)
            cnt_reg <= cnt_reg - CNT_BITS'(1);
    end

    // ---------------- output register ----------------
    logic [LEVEL_BITS-1:0] amp_emit;
    logic [LEVEL_BITS-1:0] amp_reg;
    stage_t                stage_out_reg;

    always_comb
    begin
        unique case (cur_stage_reg)
            STAGE_ATTACK:  amp_emit = lo_reg;
            STAGE_DECAY:   amp_emit = FULL_SCALE - lo_reg;
            STAGE_SUSTAIN: amp_emit = s_reg;
            STAGE_RELEASE: amp_emit = s_reg - lo_reg;
            default:       amp_emit = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit && out_free)
            out_valid_reg <= 1'b1;
        else if (dout.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit && out_free)
        begin
            amp_reg       <= amp_emit;
            stage_out_reg <= cur_stage_reg;
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.amplitude = amp_reg;
    assign dout.stage     = stage_out_reg;

    // ---------------- checks ----------------
    `LAE_ASSERT_NEXT(a_accept_to_class, clk, rst_n, din.valid && din.ready,
        step_reg == STEP_CLASS)
    `LAE_ASSERT_NOW(a_divisor_nonzero, clk, rst_n, step_reg == STEP_MUL, div_reg != '0)
    `LAE_ASSERT_NOW(a_div_count_live, clk, rst_n, step_reg == STEP_DIV, cnt_reg != '0)
    `LAE_ASSERT_NOW(a_amp_in_range, clk, rst_n, dout.valid, dout.amplitude <= FULL_SCALE)

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear ADSR envelope generator. Gate ticks go
// in on a valid/ready channel under random bursts and gaps while the output
// side stalls on its own pattern. A behavioral envelope predictor runs on
// every accepted tick and each returned word is compared field by field.
// Registers are set over APB between phases; separate tests check read-back.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lae_pkg::*;

    localparam int COUNT_BITS = 18;
    localparam int LEVEL_BITS = 16;
    localparam longint unsigned FULL_SCALE = 64'd1 << (LEVEL_BITS - 1);
    localparam longint unsigned POS_MAX = (64'd1 << (COUNT_BITS + 1)) - 1;
    localparam logic [31:0] COUNT_MAX = (32'd1 << COUNT_BITS) - 1;
    localparam logic [31:0] LEVEL_MAX = (32'd1 << LEVEL_BITS) - 1;
    localparam logic [31:0] FULL_WORD = 32'(FULL_SCALE);
    localparam int RANDOM_TICKS = 1750;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] amplitude;
        stage_t                stage;
    } env_word_t;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    lae_in_if                               din_if();
    lae_out_if #(.LEVEL_BITS(LEVEL_BITS))   dout_if();

    linear_adsr_envelope #(
        .COUNT_BITS (COUNT_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_if),
        .dout    (dout_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state and register mirror
    logic [COUNT_BITS:0]   pos_count;
    logic [COUNT_BITS-1:0] rel_count;
    stage_t                cur_stage;
    logic [COUNT_BITS-1:0] attack_len;
    logic [COUNT_BITS-1:0] decay_len;
    logic [LEVEL_BITS-1:0] sustain_lvl;
    logic [COUNT_BITS-1:0] release_len;

    env_word_t   expected_words[$];
    int          mismatches;
    int          tick_count;
    int          burst_left;
    bit          in_driving;
    bit          steady;
    int unsigned cycle_count = 0;
    int          run_left = 0;
    int          hold_left = 0;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // output side back-pressure: runs of ready, then stalls of random length
    always @(posedge clk)
    begin
        if (!rst_n)
            dout_if.ready <= 1'b0;
        else if (run_left > 0)
        begin
            dout_if.ready <= 1'b1;
            run_left--;
        end
        else if (hold_left > 0)
        begin
            dout_if.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            dout_if.ready <= 1'b1;
            run_left = $urandom_range(0, 40);
            if (steady)
                hold_left = 0;
            else if ($urandom_range(0, 4) == 0)
                hold_left = $urandom_range(8, 30);
            else
                hold_left = $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin
        env_word_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got amplitude %0d stage %0d",
                         $time, dout_if.amplitude, dout_if.stage);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (dout_if.amplitude !== want.amplitude)
                begin
                    $display("%0t: amplitude mismatch, expected %0d, got %0d",
                             $time, want.amplitude, dout_if.amplitude);
                    mismatches++;
                end
                if (dout_if.stage !== want.stage)
                begin
                    $display("%0t: stage mismatch, expected %0d, got %0d",
                             $time, want.stage, dout_if.stage);
                    mismatches++;
                end
            end
        end
    end

    // advance the envelope by one tick and return the word it should emit
    function automatic env_word_t next_envelope(input logic gate);
        longint unsigned p;
        longint unsigned a;
        longint unsigned d;
        longint unsigned r;
        longint unsigned s;
        longint unsigned rc;
        longint unsigned amp;
        env_word_t       w;
        p  = 64'(pos_count);
        a  = 64'(attack_len);
        d  = 64'(decay_len);
        r  = 64'(release_len);
        rc = 64'(rel_count);
        s  = (64'(sustain_lvl) > FULL_SCALE) ? FULL_SCALE : 64'(sustain_lvl);
        if (gate)
        begin
            if (p < a)
            begin
                w.stage = STAGE_ATTACK;
                amp = (p * FULL_SCALE) / a;
            end
            else if (p < a + d)
            begin
                w.stage = STAGE_DECAY;
                amp = FULL_SCALE - ((FULL_SCALE - s) * (p - a)) / d;
            end
            else
            begin
                w.stage = STAGE_SUSTAIN;
                amp = s;
            end
            if (p < POS_MAX)
                pos_count = pos_count + (COUNT_BITS+1)'(1);
            rel_count = '0;
        end
        else if ((cur_stage == STAGE_SUSTAIN || cur_stage == STAGE_RELEASE) &&
                 rc < r)
        begin
            w.stage = STAGE_RELEASE;
            amp = s - (s * rc) / r;
            rel_count = rel_count + COUNT_BITS'(1);
        end
        else
        begin
            w.stage = STAGE_OFF;
            amp = 64'd0;
            pos_count = '0;
            rel_count = '0;
        end
        cur_stage = w.stage;
        w.amplitude = amp[LEVEL_BITS-1:0];
        return w;
    endfunction

    // one gate word, held until taken; bursts end in random gaps
    task automatic send_tick(input logic gate);
        int gap;
        din_if.gate <= gate;
        if (!in_driving)
        begin
            din_if.valid <= 1'b1;
            in_driving = 1'b1;
        end
        do @(posedge clk); while (!din_if.ready);
        expected_words.push_back(next_envelope(gate));
        tick_count++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            if (steady)
                gap = 0;
            else if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(10, 40);
            else
                gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                din_if.valid <= 1'b0;
                in_driving = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        if (in_driving)
        begin
            din_if.valid <= 1'b0;
            in_driving = 1'b0;
        end
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // psel stays up across back-to-back transfers; bus_release drops it
    task automatic apb_access(input reg_idx_t idx, input logic write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel   <= 1'b1;
        pwrite <= write;
        paddr  <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        penable <= 1'b0;
    endtask

    task automatic bus_release();
        psel <= 1'b0;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] data;
        logic [31:0] unused;
        // junk in the unused upper bits now and then
        data = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
        if (idx == REG_SUSTAIN)
            data[LEVEL_BITS-1:0] = value[LEVEL_BITS-1:0];
        else
            data[COUNT_BITS-1:0] = value[COUNT_BITS-1:0];
        apb_access(idx, 1'b1, data, unused);
        case (idx)
            REG_ATTACK:  attack_len  = data[COUNT_BITS-1:0];
            REG_DECAY:   decay_len   = data[COUNT_BITS-1:0];
            REG_SUSTAIN: sustain_lvl = data[LEVEL_BITS-1:0];
            REG_RELEASE: release_len = data[COUNT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic read_check(input reg_idx_t idx);
        logic [31:0] want;
        logic [31:0] got;
        case (idx)
            REG_ATTACK:  want = 32'(attack_len);
            REG_DECAY:   want = 32'(decay_len);
            REG_SUSTAIN: want = 32'(sustain_lvl);
            default:     want = 32'(release_len);
        endcase
        apb_access(idx, 1'b0, 32'd0, got);
        if (got !== want)
        begin
            $display("%0t: register %0d read mismatch, expected %0d, got %0d",
                     $time, idx, want, got);
            mismatches++;
        end
    endtask

    task automatic set_envelope(input logic [31:0] a, input logic [31:0] d,
                                input logic [31:0] s, input logic [31:0] r);
        wait_idle();
        write_reg(REG_ATTACK, a);
        write_reg(REG_DECAY, d);
        write_reg(REG_SUSTAIN, s);
        write_reg(REG_RELEASE, r);
        bus_release();
    endtask

    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 19))
            0, 1, 2: return 32'd0;
            3:       return COUNT_MAX;
            4:       return $urandom_range(13, COUNT_MAX);
            5:       return 32'd1;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return FULL_WORD;
            2:       return $urandom_range(FULL_WORD + 32'd1, LEVEL_MAX);
            3:       return LEVEL_MAX;
            default: return $urandom_range(1, FULL_WORD - 32'd1);
        endcase
    endfunction

    // reset register values, then a short note under them cut off in attack
    task automatic test_reset_state();
        read_check(REG_ATTACK);
        read_check(REG_DECAY);
        read_check(REG_SUSTAIN);
        read_check(REG_RELEASE);
        bus_release();
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_register_access();
        reg_idx_t    regs[4] = '{REG_ATTACK, REG_DECAY, REG_SUSTAIN, REG_RELEASE};
        logic [31:0] top;
        wait_idle();
        foreach (regs[i])
        begin
            top = (regs[i] == REG_SUSTAIN) ? LEVEL_MAX : COUNT_MAX;
            write_reg(regs[i], 32'd0);
            read_check(regs[i]);
            write_reg(regs[i], top);
            read_check(regs[i]);
            write_reg(regs[i], $urandom);
            read_check(regs[i]);
        end
        bus_release();
    endtask

    task automatic test_directed_cases();
        // full cycle: attack, decay, sustain boundary, release, re-trigger
        set_envelope(32'd4, 32'd4, 32'd20000, 32'd3);
        repeat (9) send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        // drop before sustain
        repeat (2) send_tick(1'b1);
        send_tick(1'b0);
        // zero stage lengths, sustain clamped above full scale
        set_envelope(32'd0, 32'd0, LEVEL_MAX, 32'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        // longest lengths, zero sustain
        set_envelope(COUNT_MAX, COUNT_MAX, 32'd0, COUNT_MAX);
        send_tick(1'b1);
        send_tick(1'b0);
        // full sustain into the longest release
        set_envelope(32'd0, 32'd0, FULL_WORD, COUNT_MAX);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
    endtask

    task automatic test_random_envelopes();
        int start_ticks;
        int phase_end;
        int hold;
        int fall;
        start_ticks = tick_count;
        while (tick_count - start_ticks < RANDOM_TICKS)
        begin
            steady = ($urandom_range(0, 3) == 0);
            set_envelope(pick_length(), pick_length(), pick_level(), pick_length());
            phase_end = tick_count + int'($urandom_range(40, 100));
            while (tick_count < phase_end)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
                end
                else
                begin
                    // mostly hold past the decay so sustain and release get reached
                    if (int'(attack_len) + int'(decay_len) <= 40 &&
                        $urandom_range(0, 2) != 0)
                        hold = int'(attack_len) + int'(decay_len) +
                               int'($urandom_range(1, 6));
                    else
                        hold = $urandom_range(1, 40);
                    repeat (hold) send_tick(1'b1);
                    if (int'(release_len) <= 30)
                        fall = $urandom_range(0, 32'(release_len) + 32'd3);
                    else
                        fall = $urandom_range(1, 30);
                    repeat (fall) send_tick(1'b0);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        repeat ($urandom_range(1, 3)) send_tick(1'b1);
                        repeat ($urandom_range(1, 8)) send_tick(1'b0);
                    end
                end
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        din_if.valid  = 1'b0;
        din_if.gate   = 1'b0;
        mismatches    = 0;
        tick_count    = 0;
        burst_left    = 0;
        in_driving    = 1'b0;
        steady        = 1'b0;
        pos_count     = '0;
        rel_count     = '0;
        cur_stage     = STAGE_OFF;
        attack_len    = 18'd48000;
        decay_len     = 18'd72000;
        sustain_lvl   = 16'd16384;
        release_len   = 18'd96000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_register_access();
        test_directed_cases();
        test_random_envelopes();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* linear_adsr_envelope.f */
+incdir+rtl/core
rtl/core/lae_pkg.sv
rtl/core/lae_if.sv
rtl/core/linear_adsr_envelope.sv
tb/sv/tb.sv
